/* design/fdsa_pkg.sv */
// Shared types and constants for the Forth data stack core.
// Holds the word, item and control types used by the cells, the decoder and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fdsa_pkg;

    // Word and field widths
    localparam int WORD_W          = 32;
    localparam int MODE_W          = 4;
    localparam int DEPTH_FIELD_W   = 5;
    localparam int STACK_DEPTH_DEF = 16;
    // Number of top cells that the decoder may overwrite directly
    localparam int TOP_CELLS       = 3;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SUB   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_EQUAL = 4'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_DUP   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_DROP  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SWAP  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_OVER  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_NOP   = 4'd9;

    typedef logic [WORD_W-1:0] word_t;

    // Direction the whole chain moves in one step
    typedef enum logic [1:0] {
        SHIFT_HOLD = 2'd0,
        SHIFT_UP   = 2'd1,
        SHIFT_DOWN = 2'd2
    } shift_t;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] literal;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] top_value;
        logic [DEPTH_FIELD_W-1:0] stack_depth;
        logic                     overflow;
        logic                     underflow;
    } out_item_t;

    // Decoder to chain: move, direct writes into the top cells, flags and new top
    typedef struct packed {
        shift_t                        shift;
        logic [TOP_CELLS-1:0]          wr_en;
        logic [TOP_CELLS-1:0][WORD_W-1:0] wr_data;
        logic                          overflow;
        logic                          underflow;
        word_t                         top_next;
    } stk_ctl_t;

    // Per-cell step command
    typedef struct packed {
        logic   load;
        shift_t shift;
    } cell_ctl_t;

endpackage : fdsa_pkg

`default_nettype wire

/* design/fdsa_cell.sv */
// One stack cell: holds a single word and takes it from a neighbor or a direct write.
// Depends on fdsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdsa_cell (
    input  wire                 aclk,
    input  fdsa_pkg::cell_ctl_t ctl,
    input  fdsa_pkg::word_t     above_word,
    input  fdsa_pkg::word_t     below_word,
    input  wire                 wr_en,
    input  fdsa_pkg::word_t     wr_data,
    output fdsa_pkg::word_t     cell_word
);
    import fdsa_pkg::*;

    word_t word_reg;
    word_t word_next;

    // Pick the next word: direct write wins, else move with the chain
    always_comb begin
        word_next = word_reg;
        if (wr_en) begin
            word_next = wr_data;
        end else begin
            unique case (ctl.shift)
                SHIFT_HOLD: word_next = word_reg;
                SHIFT_UP:   word_next = below_word;
                SHIFT_DOWN: word_next = above_word;
                default:    word_next = word_reg;
            endcase
        end
    end

    // Advance only on an accepted word
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            word_reg <= word_next;
        end
    end

    assign cell_word = word_reg;

endmodule : fdsa_cell

`default_nettype wire

/* design/fdsa_ctrl.sv */
// Operation decoder: turns one opcode, the entry count and the top two cells into
// a chain move, direct writes to the top cells, the new count and the flags.
// Depends on fdsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdsa_ctrl #(
    parameter int STACK_DEPTH = fdsa_pkg::STACK_DEPTH_DEF,
    localparam int CNT_W      = $clog2(STACK_DEPTH + 1)
) (
    input  fdsa_pkg::in_item_t  item,
    input  wire [CNT_W-1:0]     count,
    input  fdsa_pkg::word_t     top0,
    input  fdsa_pkg::word_t     top1,
    output fdsa_pkg::stk_ctl_t  ctl,
    output logic [CNT_W-1:0]    count_next
);
    import fdsa_pkg::*;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

    logic  stk_empty;
    logic  has_two;
    logic  is_full;
    word_t pop_a;
    word_t pop_b;
    word_t alu_res;

    // Values popped first and second; empty pops read zero
    always_comb begin
        stk_empty = (count == '0);
        has_two   = (count > CNT_W'(1));
        is_full   = (count == CNT_FULL);
        pop_a     = stk_empty ? '0 : top0;
        pop_b     = has_two ? top1 : '0;
    end

    // Binary result for add, subtract and equal
    always_comb begin
        unique case (item.mode)
            MODE_ADD:   alu_res = pop_a + pop_b;
            MODE_SUB:   alu_res = pop_b - pop_a;
            MODE_EQUAL: alu_res = (pop_a == pop_b) ? '1 : '0;
            default:    alu_res = '0;
        endcase
    end

    // Decode the net effect of each pop and push sequence
    always_comb begin
        ctl            = '0;
        ctl.shift      = SHIFT_HOLD;
        count_next     = count;
        unique case (item.mode)
            MODE_PUSH: begin
                if (is_full) begin
                    ctl.overflow = 1'b1;
                end else begin
                    ctl.shift      = SHIFT_DOWN;
                    ctl.wr_en[0]   = 1'b1;
                    ctl.wr_data[0] = word_t'(item.literal);
                    count_next     = count + CNT_W'(1);
                end
            end
            MODE_ADD, MODE_SUB, MODE_EQUAL: begin
                ctl.wr_en[0]   = 1'b1;
                ctl.wr_data[0] = alu_res;
                if (has_two) begin
                    ctl.shift  = SHIFT_UP;
                    count_next = count - CNT_W'(1);
                end else begin
                    ctl.underflow = 1'b1;
                    count_next    = CNT_W'(1);
                end
            end
            MODE_PEEK: begin
                ctl.underflow = stk_empty;
            end
            MODE_DUP: begin
                if (stk_empty) begin
                    ctl.underflow  = 1'b1;
                    ctl.wr_en[0]   = 1'b1;
                    ctl.wr_data[0] = '0;
                    count_next     = CNT_W'(1);
                end else if (is_full) begin
                    ctl.overflow = 1'b1;
                end else begin
                    ctl.shift      = SHIFT_DOWN;
                    ctl.wr_en[0]   = 1'b1;
                    ctl.wr_data[0] = top0;
                    count_next     = count + CNT_W'(1);
                end
            end
            MODE_DROP: begin
                if (stk_empty) begin
                    ctl.underflow = 1'b1;
                end else begin
                    ctl.shift  = SHIFT_UP;
                    count_next = count - CNT_W'(1);
                end
            end
            MODE_SWAP: begin
                if (has_two) begin
                    ctl.wr_en[1:0]  = 2'b11;
                    ctl.wr_data[0]  = top1;
                    ctl.wr_data[1]  = top0;
                end else if (!stk_empty) begin
                    // One entry: it sinks one place, a zero lands on top
                    ctl.underflow   = 1'b1;
                    ctl.shift       = SHIFT_DOWN;
                    ctl.wr_en[0]    = 1'b1;
                    ctl.wr_data[0]  = '0;
                    count_next      = CNT_W'(2);
                end else begin
                    ctl.underflow   = 1'b1;
                    ctl.wr_en[1:0]  = 2'b11;
                    count_next      = CNT_W'(2);
                end
            end
            MODE_OVER: begin
                if (has_two) begin
                    if (is_full) begin
                        ctl.overflow = 1'b1;
                    end else begin
                        ctl.shift      = SHIFT_DOWN;
                        ctl.wr_en[0]   = 1'b1;
                        ctl.wr_data[0] = top1;
                        count_next     = count + CNT_W'(1);
                    end
                end else if (!stk_empty) begin
                    // One entry a: result is 0 a 0, last push lost on a two-deep stack
                    ctl.underflow = 1'b1;
                    if (STACK_DEPTH >= TOP_CELLS) begin
                        ctl.shift      = SHIFT_DOWN;
                        ctl.wr_en[0]   = 1'b1;
                        ctl.wr_en[2]   = 1'b1;
                        count_next     = CNT_W'(3);
                    end else begin
                        ctl.overflow   = 1'b1;
                        ctl.wr_en[1]   = 1'b1;
                        count_next     = CNT_W'(2);
                    end
                end else begin
                    // Empty: pushes three zeros, or two zeros with overflow on a two-deep stack
                    ctl.underflow = 1'b1;
                    if (STACK_DEPTH >= TOP_CELLS) begin
                        ctl.wr_en  = '1;
                        count_next = CNT_W'(3);
                    end else begin
                        ctl.overflow   = 1'b1;
                        ctl.wr_en[1:0] = 2'b11;
                        count_next     = CNT_W'(2);
                    end
                end
            end
            default: begin
                ctl.shift = SHIFT_HOLD;
            end
        endcase

        // New top word as the chain will hold it after this step
        if (count_next == '0) begin
            ctl.top_next = '0;
        end else if (ctl.wr_en[0]) begin
            ctl.top_next = ctl.wr_data[0];
        end else if (ctl.shift == SHIFT_UP) begin
            ctl.top_next = top1;
        end else begin
            ctl.top_next = top0;
        end
    end

endmodule : fdsa_ctrl

`default_nettype wire

/* design/forth_data_stack_alu_core.sv */
// Top level of the Forth data stack core: a chain of word cells, the operation
// decoder, the entry count and the result register.
// Depends on fdsa_pkg, fdsa_cell and fdsa_ctrl.
// Result: a result word is valid in the cycle after its operation word is accepted.
// Throughput: one operation word per cycle while m_ready stays high; every step
// moves the cell chain by at most one place, so the decoder and one cell mux set the cycle.
// Reset: clears the entry count (stack empty) and the result valid; stack words are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module forth_data_stack_alu_core #(
    parameter int STACK_DEPTH = fdsa_pkg::STACK_DEPTH_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  fdsa_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output fdsa_pkg::out_item_t m_data
);
    import fdsa_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    out_item_t                    m_data_reg;
    out_item_t                    m_data_next;
    logic                         accept;
    stk_ctl_t                     stk_ctl;
    cell_ctl_t                    cell_ctl;
    word_t [STACK_DEPTH-1:0]      cell_words;
    logic [CNT_W+DEPTH_FIELD_W-1:0] depth_wide;

    // Take a new word out of reset whenever the result slot is free or being drained
    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    fdsa_ctrl #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_ctrl (
        .item       (s_data),
        .count      (count_reg),
        .top0       (cell_words[0]),
        .top1       (cell_words[1]),
        .ctl        (stk_ctl),
        .count_next (count_next)
    );

    assign cell_ctl.load  = accept;
    assign cell_ctl.shift = stk_ctl.shift;

    // Row of cells, top of stack in cell 0
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        word_t above_w;
        word_t below_w;
        logic  wr_en_w;
        word_t wr_data_w;

        if (i == 0) begin : g_first
            assign above_w = '0;
        end else begin : g_mid_above
            assign above_w = cell_words[i-1];
        end

        if (i == STACK_DEPTH - 1) begin : g_last
            assign below_w = '0;
        end else begin : g_mid_below
            assign below_w = cell_words[i+1];
        end

        if (i < TOP_CELLS) begin : g_top
            assign wr_en_w   = stk_ctl.wr_en[i];
            assign wr_data_w = stk_ctl.wr_data[i];
        end else begin : g_deep
            assign wr_en_w   = 1'b0;
            assign wr_data_w = '0;
        end

        fdsa_cell u_cell (
            .aclk       (aclk),
            .ctl        (cell_ctl),
            .above_word (above_w),
            .below_word (below_w),
            .wr_en      (wr_en_w),
            .wr_data    (wr_data_w),
            .cell_word  (cell_words[i])
        );
    end

    // Build the result word
    always_comb begin
        depth_wide              = (CNT_W + DEPTH_FIELD_W)'(count_next);
        m_data_next.top_value   = stk_ctl.top_next;
        m_data_next.stack_depth = depth_wide[DEPTH_FIELD_W-1:0];
        m_data_next.overflow    = stk_ctl.overflow;
        m_data_next.underflow   = stk_ctl.underflow;
        m_valid_next            = accept || (m_valid_reg && !m_ready);
    end

    // Hold control state under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    // Load the result payload on accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Count never exceeds the stack size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("entry count above stack depth");

    // A push on a full stack leaves the count at full
    a_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.mode == MODE_PUSH && count_reg == CNT_W'(STACK_DEPTH)
        |=> count_reg == CNT_W'(STACK_DEPTH))
        else $error("push on full stack changed the count");

    // Drop on a non-empty stack removes exactly one entry
    a_drop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.mode == MODE_DROP && count_reg != '0
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("drop did not remove one entry");

    // An empty stack shows a zero top
    a_empty_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && count_reg == '0 |-> m_data_reg.top_value == '0)
        else $error("nonzero top on empty stack");

    // Every accepted word yields a pending result
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted word produced no result");

endmodule : forth_data_stack_alu_core

`default_nettype wire

/* test/tb_forth_data_stack_alu_core.sv */
// Self-checking bench for forth_data_stack_alu_core: directed and random stack operations,
// each result word checked against a local model of the 16-entry data stack.
// Depends on fdsa_pkg and the RTL of forth_data_stack_alu_core.
`timescale 1ns / 1ps

module tb_forth_data_stack_alu_core;
    import fdsa_pkg::*;

    localparam int DEPTH       = STACK_DEPTH_DEF;
    localparam int RAND_ITEMS  = 1350;
    localparam int CALM_ITEMS  = 150;
    localparam int STALL_AT    = 400;
    localparam int STALL_LEN   = 300;
    localparam int CYCLE_LIMIT = 400000;

    // Directed stimulus row: operation word, repeat count, optional hand-typed result
    typedef struct packed {
        in_item_t  op;
        int        reps;
        logic      typed;
        out_item_t want;
    } plan_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // Local copy of the stack and per-operation flags
    word_t       stk_words [DEPTH];
    int          stk_count = 0;
    logic        push_lost;
    logic        pop_empty;
    out_item_t   pending_views [$];
    plan_row_t   plan [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    logic        calm = 1'b0;
    logic        long_stall_req = 1'b0;
    logic        long_stall_active = 1'b0;

    forth_data_stack_alu_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // Stack primitives: single push, single pop, read of the top
    function automatic void push_word(word_t v);
        if (stk_count >= DEPTH) begin
            push_lost = 1'b1;
        end else begin
            stk_words[stk_count] = v;
            stk_count++;
        end
    endfunction

    function automatic word_t pop_word();
        if (stk_count == 0) begin
            pop_empty = 1'b1;
            return '0;
        end
        stk_count--;
        return stk_words[stk_count];
    endfunction

    function automatic word_t top_word();
        if (stk_count == 0) begin
            pop_empty = 1'b1;
            return '0;
        end
        return stk_words[stk_count - 1];
    endfunction

    // Execute one operation on the local stack and return the resulting view
    function automatic out_item_t apply_stack_op(in_item_t op);
        word_t     a;
        word_t     b;
        out_item_t view;
        push_lost = 1'b0;
        pop_empty = 1'b0;
        case (op.mode)
            MODE_PUSH: begin
                push_word(op.literal);
            end
            MODE_ADD: begin
                a = pop_word();
                b = pop_word();
                push_word(a + b);
            end
            MODE_SUB: begin
                a = pop_word();
                b = pop_word();
                push_word(b - a);
            end
            MODE_EQUAL: begin
                a = pop_word();
                b = pop_word();
                push_word((a == b) ? '1 : '0);
            end
            MODE_PEEK: begin
                void'(top_word());
            end
            MODE_DUP: begin
                push_word(top_word());
            end
            MODE_DROP: begin
                void'(pop_word());
            end
            MODE_SWAP: begin
                a = pop_word();
                b = pop_word();
                push_word(a);
                push_word(b);
            end
            MODE_OVER: begin
                a = pop_word();
                b = pop_word();
                push_word(b);
                push_word(a);
                push_word(b);
            end
            default: ;
        endcase
        view.top_value   = (stk_count > 0) ? stk_words[stk_count - 1] : '0;
        view.stack_depth = stk_count[DEPTH_FIELD_W-1:0];
        view.overflow    = push_lost;
        view.underflow   = pop_empty;
        return view;
    endfunction

    function automatic plan_row_t mk_row(logic [MODE_W-1:0] mode, word_t lit, int reps,
                                         logic typed, word_t top,
                                         logic [DEPTH_FIELD_W-1:0] depth,
                                         logic ovf, logic unf);
        plan_row_t row;
        row.op.mode          = mode;
        row.op.literal       = lit;
        row.reps             = reps;
        row.typed            = typed;
        row.want.top_value   = top;
        row.want.stack_depth = depth;
        row.want.overflow    = ovf;
        row.want.underflow   = unf;
        return row;
    endfunction

    // Pick a random operation; lean 0 grows the stack, 1 shrinks it, 2 is uniform
    function automatic in_item_t rand_stack_op(int lean);
        in_item_t op;
        int       r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            op.mode = MODE_W'($urandom_range(MODE_NOP + 1, {MODE_W{1'b1}}));
        end else if (lean == 0) begin
            if (r < 40)      op.mode = MODE_PUSH;
            else if (r < 60) op.mode = MODE_DUP;
            else if (r < 75) op.mode = MODE_OVER;
            else if (r < 82) op.mode = MODE_SWAP;
            else if (r < 88) op.mode = MODE_PEEK;
            else if (r < 94) op.mode = MODE_ADD;
            else             op.mode = MODE_EQUAL;
        end else if (lean == 1) begin
            if (r < 15)      op.mode = MODE_ADD;
            else if (r < 30) op.mode = MODE_SUB;
            else if (r < 45) op.mode = MODE_EQUAL;
            else if (r < 70) op.mode = MODE_DROP;
            else if (r < 78) op.mode = MODE_SWAP;
            else if (r < 84) op.mode = MODE_PEEK;
            else if (r < 92) op.mode = MODE_PUSH;
            else             op.mode = MODE_DUP;
        end else begin
            op.mode = MODE_W'($urandom_range(MODE_PUSH, MODE_NOP));
        end
        // Mix extremes and small values in so that equality often holds
        r = $urandom_range(0, 19);
        case (r)
            0:       op.literal = 32'h7FFF_FFFF;
            1:       op.literal = 32'h8000_0000;
            2:       op.literal = '1;
            3:       op.literal = '0;
            4, 5:    op.literal = $urandom_range(0, 3);
            default: op.literal = $urandom;
        endcase
        return op;
    endfunction

    // Offer one word, hold it until accepted, then record the view it must produce
    task automatic offer_word(in_item_t op, logic typed, out_item_t want);
        out_item_t view;
        s_valid <= 1'b1;
        s_data  <= op;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        view = apply_stack_op(op);
        pending_views.push_back(typed ? want : view);
    endtask

    // Drop valid for a random burst now and then
    task automatic maybe_pause();
        if (!calm && !long_stall_active && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    // Receiver: random stall bursts, one long hold-off on request, none at the end
    initial begin
        forever begin
            if (long_stall_req && !long_stall_active) begin
                long_stall_active = 1'b1;
                m_ready <= 1'b0;
                repeat (STALL_LEN) @(posedge aclk);
                long_stall_req    = 1'b0;
                long_stall_active = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    // Compare each result word with the oldest outstanding view
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_views.size() == 0) begin
                $error("result word with nothing outstanding: top=%h depth=%0d",
                       m_data.top_value, m_data.stack_depth);
                mismatches++;
            end else begin
                want = pending_views.pop_front();
                if (m_data.top_value !== want.top_value) begin
                    $error("top_value: expected %h, got %h", want.top_value, m_data.top_value);
                    mismatches++;
                end
                if (m_data.stack_depth !== want.stack_depth) begin
                    $error("stack_depth: expected %0d, got %0d",
                           want.stack_depth, m_data.stack_depth);
                    mismatches++;
                end
                if (m_data.overflow !== want.overflow) begin
                    $error("overflow: expected %b, got %b", want.overflow, m_data.overflow);
                    mismatches++;
                end
                if (m_data.underflow !== want.underflow) begin
                    $error("underflow: expected %b, got %b", want.underflow, m_data.underflow);
                    mismatches++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[forth_data_stack_alu_core] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int lean;
        int lean_left;
        // Empty-stack reads and pops, wrap of add and sub, equality, then fill to full
        plan.push_back(mk_row(MODE_PEEK,  '0,           1,  1'b1, '0,           5'd0, 1'b0, 1'b1));
        plan.push_back(mk_row(MODE_DUP,   '0,           1,  1'b1, '0,           5'd1, 1'b0, 1'b1));
        plan.push_back(mk_row(MODE_ADD,   '0,           1,  1'b1, '0,           5'd1, 1'b0, 1'b1));
        plan.push_back(mk_row(MODE_DROP,  '0,           1,  1'b1, '0,           5'd0, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_DROP,  '1,           1,  1'b1, '0,           5'd0, 1'b0, 1'b1));
        plan.push_back(mk_row(MODE_PUSH,  32'h7FFF_FFFF, 1, 1'b1, 32'h7FFF_FFFF, 5'd1, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_PUSH,  32'h1,        1,  1'b1, 32'h1,        5'd2, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_ADD,   '0,           1,  1'b1, 32'h8000_0000, 5'd1, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_PUSH,  32'h8000_0000, 1, 1'b1, 32'h8000_0000, 5'd2, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_EQUAL, '0,           1,  1'b1, '1,           5'd1, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_PUSH,  32'h8000_0000, 1, 1'b1, 32'h8000_0000, 5'd2, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_SUB,   '0,           1,  1'b1, 32'h7FFF_FFFF, 5'd1, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_SWAP,  '0,           1,  1'b0, '0, '0, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_PUSH,  32'h1234_5678, 1, 1'b0, '0, '0, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_OVER,  '0,           1,  1'b0, '0, '0, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_EQUAL, '0,           1,  1'b0, '0, '0, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_NOP,   32'h5A5A_5A5A, 1, 1'b0, '0, '0, 1'b0, 1'b0));
        plan.push_back(mk_row({MODE_W{1'b1}}, '1,       1,  1'b0, '0, '0, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_DUP,   '0,           13, 1'b0, '0, '0, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_PUSH,  '1,           1,  1'b0, '0, '0, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_OVER,  '0,           1,  1'b0, '0, '0, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_PEEK,  '0,           1,  1'b0, '0, '0, 1'b0, 1'b0));
        plan.push_back(mk_row(MODE_SUB,   '0,           1,  1'b0, '0, '0, 1'b0, 1'b0));

        // Hold reset, then release once
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        foreach (plan[i]) begin
            repeat (plan[i].reps) begin
                offer_word(plan[i].op, plan[i].typed, plan[i].want);
                maybe_pause();
            end
        end

        // Pause the sender until every outstanding result has come back
        s_valid <= 1'b0;
        while (pending_views.size() != 0) @(posedge aclk);

        // Random part: stretches that grow, shrink or mix, so both bounds are hit
        lean_left = 0;
        lean      = 2;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (lean_left == 0) begin
                lean      = $urandom_range(0, 2);
                lean_left = $urandom_range(8, 40);
            end
            lean_left--;
            if (n == STALL_AT)
                long_stall_req = 1'b1;
            if (n == RAND_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            offer_word(rand_stack_op(lean), 1'b0, '0);
            maybe_pause();
        end
        s_valid <= 1'b0;

        // Drain, then wait for any stray result word
        while (pending_views.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("[forth_data_stack_alu_core] OK");
        else
            $display("[forth_data_stack_alu_core] ERROR");
        $finish;
    end

endmodule
